// File: hdl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CPTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CPTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/cpts_pkg.sv
// Shared types, opcodes and constants of the counter/priority task scheduler.
package cpts_pkg;

	localparam int TASK_COUNT_DEF = 64;
	localparam int SLOT_W         = 6;
	localparam int PRIO_W         = 8;
	localparam int SLICE_W        = 9;
	localparam int OP_W           = 2;

	localparam logic [SLICE_W-1:0] SLICE_MAX = 9'd511;

	// Operation codes carried in the input tuser.
	localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_SCHED = 2'd2;

	// One task table entry.
	typedef struct packed {
		logic               present;
		logic               runnable;
		logic [PRIO_W-1:0]  prio;
		logic [SLICE_W-1:0] slice;
	} cpts_entry_t;

	// Value an entry holds until it is first written.
	localparam cpts_entry_t ENTRY_RESET = '{
		present:  1'b0,
		runnable: 1'b0,
		prio:     8'd1,
		slice:    9'd0
	};

	// One input word, unpacked.
	typedef struct packed {
		logic [OP_W-1:0]    opcode;
		logic               kernel_mode;
		logic [SLOT_W-1:0]  slot;
		logic               present;
		logic               runnable;
		logic [PRIO_W-1:0]  priority_req;
		logic [SLICE_W-1:0] slice_value;
	} cpts_item_t;

	// One result word, unpacked.
	typedef struct packed {
		logic               switched;
		logic [SLOT_W-1:0]  task_index;
		logic               refreshed;
		logic [SLICE_W-1:0] current_slice;
	} cpts_result_t;

endpackage

// File: hdl/cpts_table.sv
// Task table memory with per-entry valid bits and a registered read port.
module cpts_table #(
	parameter  int TASK_COUNT = cpts_pkg::TASK_COUNT_DEF,
	localparam int IDX_W      = $clog2(TASK_COUNT)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [IDX_W-1:0]    rd_addr,
	output cpts_pkg::cpts_entry_t rd_data,
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_addr,
	input  cpts_pkg::cpts_entry_t wr_data
);
	import cpts_pkg::*;

	cpts_entry_t             mem [TASK_COUNT];
	logic [TASK_COUNT-1:0]   valid_q;
	cpts_entry_t             rd_data_q;

	// Entry storage, one write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Valid bits: an entry never written reads as its reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_data_q <= valid_q[rd_addr] ? mem[rd_addr] : ENTRY_RESET;
	end

	assign rd_data = rd_data_q;

endmodule

// File: hdl/cpts_core.sv
// Sequencer and shared compare/refill unit that walks the task table.
module cpts_core #(
	parameter  int TASK_COUNT = cpts_pkg::TASK_COUNT_DEF,
	localparam int IDX_W      = $clog2(TASK_COUNT)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  cpts_pkg::cpts_item_t   in_item,
	output logic                   res_valid,
	input  logic                   res_ready,
	output cpts_pkg::cpts_result_t res,
	output logic [IDX_W-1:0]       rd_addr,
	input  cpts_pkg::cpts_entry_t  rd_data,
	output logic                   wr_en,
	output logic [IDX_W-1:0]       wr_addr,
	output cpts_pkg::cpts_entry_t  wr_data
);
	import cpts_pkg::*;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_TICK_RD  = 4'd1;
	localparam logic [3:0] ST_TICK_UPD = 4'd2;
	localparam logic [3:0] ST_SCAN     = 4'd3;
	localparam logic [3:0] ST_REFILL   = 4'd4;
	localparam logic [3:0] ST_OUT_RD   = 4'd5;
	localparam logic [3:0] ST_OUT_DAT  = 4'd6;
	localparam logic [3:0] ST_DONE     = 4'd7;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TASK_COUNT - 1);
	localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

	logic [3:0]         state_q;
	logic [IDX_W-1:0]   cur_q;
	logic [IDX_W-1:0]   cnt_q;
	logic               issue_done_q;
	logic               pend_s1;
	logic [IDX_W-1:0]   addr_s1;
	logic               any_q;
	logic [SLICE_W-1:0] top_q;
	logic [IDX_W-1:0]   best_q;
	logic               refilled_q;
	logic               switched_q;
	logic               kmode_q;
	cpts_result_t       res_q;

	logic                    slot_ok;
	logic [IDX_W+SLOT_W-1:0] slot_ext;
	logic [IDX_W+SLOT_W-1:0] cur_ext;
	logic                    cand;
	logic [SLICE_W:0]        refill_sum;
	logic [SLICE_W-1:0]      refill_val;
	logic                    scanning;

	// Address and range check of a table write.
	assign slot_ext = {{IDX_W{1'b0}}, in_item.slot};
	assign slot_ok  = (9'(in_item.slot) < 9'(TASK_COUNT));
	assign cur_ext  = {{SLOT_W{1'b0}}, cur_q};

	// Shared unit: candidate compare and refill of one entry.
	assign cand = rd_data.present && rd_data.runnable &&
		(!any_q || (rd_data.slice > top_q));
	assign refill_sum = (SLICE_W+1)'(rd_data.slice[SLICE_W-1:1]) +
		(SLICE_W+1)'(rd_data.prio);
	assign refill_val = (refill_sum > (SLICE_W+1)'(SLICE_MAX)) ? SLICE_MAX
		: refill_sum[SLICE_W-1:0];

	assign scanning = (state_q == ST_SCAN) || (state_q == ST_REFILL);

	// Read address follows the sweep counter, otherwise the current task.
	assign rd_addr = scanning ? cnt_q : cur_q;

	// Table writes: loads, tick countdown and refill write-back.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cur_q;
		wr_data = rd_data;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && (in_item.opcode == OP_WRITE) && slot_ok) begin
					wr_en            = 1'b1;
					wr_addr          = slot_ext[IDX_W-1:0];
					wr_data.present  = in_item.present;
					wr_data.runnable = in_item.runnable;
					wr_data.prio     = in_item.priority_req;
					wr_data.slice    = in_item.slice_value;
				end
			end
			ST_TICK_UPD: begin
				wr_en         = 1'b1;
				wr_data.slice = (rd_data.slice > 9'd1) ? (rd_data.slice - 9'd1) : '0;
			end
			ST_REFILL: begin
				if (pend_s1 && rd_data.present) begin
					wr_en         = 1'b1;
					wr_addr       = addr_s1;
					wr_data.slice = refill_val;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cur_q        <= '0;
			cnt_q        <= '0;
			issue_done_q <= 1'b0;
			pend_s1      <= 1'b0;
			any_q        <= 1'b0;
			top_q        <= '0;
			best_q       <= '0;
			refilled_q   <= 1'b0;
			switched_q   <= 1'b0;
			kmode_q      <= 1'b0;
		end else begin
			pend_s1 <= scanning && !issue_done_q;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						kmode_q    <= in_item.kernel_mode;
						refilled_q <= 1'b0;
						switched_q <= 1'b0;
						case (in_item.opcode)
							OP_TICK: begin
								state_q <= ST_TICK_RD;
							end
							OP_SCHED: begin
								switched_q   <= 1'b1;
								cnt_q        <= IDX_LAST;
								issue_done_q <= 1'b0;
								any_q        <= 1'b0;
								state_q      <= ST_SCAN;
							end
							default: begin
								state_q <= ST_OUT_RD;
							end
						endcase
					end
				end
				ST_TICK_RD: begin
					state_q <= ST_TICK_UPD;
				end
				ST_TICK_UPD: begin
					if ((rd_data.slice > 9'd1) || kmode_q) begin
						state_q <= ST_OUT_RD;
					end else begin
						switched_q   <= 1'b1;
						cnt_q        <= IDX_LAST;
						issue_done_q <= 1'b0;
						any_q        <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// Slots are read from the top down; strict compare keeps the highest slot.
					if (!issue_done_q) begin
						if (cnt_q == IDX_ONE) begin
							issue_done_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q - IDX_ONE;
						end
					end
					if (pend_s1 && cand) begin
						top_q  <= rd_data.slice;
						best_q <= addr_s1;
						any_q  <= 1'b1;
					end
					if (issue_done_q && !pend_s1) begin
						if (any_q && (top_q == '0) && !refilled_q) begin
							cnt_q        <= IDX_ONE;
							issue_done_q <= 1'b0;
							state_q      <= ST_REFILL;
						end else begin
							cur_q   <= any_q ? best_q : '0;
							state_q <= ST_OUT_RD;
						end
					end
				end
				ST_REFILL: begin
					// Read-modify-write sweep from slot 1 upward.
					if (!issue_done_q) begin
						if (cnt_q == IDX_LAST) begin
							issue_done_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + IDX_ONE;
						end
					end
					if (issue_done_q && !pend_s1) begin
						refilled_q   <= 1'b1;
						cnt_q        <= IDX_LAST;
						issue_done_q <= 1'b0;
						any_q        <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_OUT_RD: begin
					state_q <= ST_OUT_DAT;
				end
				ST_OUT_DAT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Pipeline address of the read in flight, and the result word.
	always_ff @(posedge clk) begin
		addr_s1 <= cnt_q;
		if (state_q == ST_OUT_DAT) begin
			res_q.switched      <= switched_q;
			res_q.task_index    <= cur_ext[SLOT_W-1:0];
			res_q.refreshed     <= refilled_q;
			res_q.current_slice <= rd_data.slice;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

endmodule

// File: hdl/counter_priority_task_scheduler.sv
// A write or an unused opcode reads back the current task's entry; a tick first counts down
// its slice and may start a selection, which takes up to two table scans and one refill sweep.
// Throughput: one word at a time, set by the single table read port, one entry per cycle.
// The next word is taken while the previous result still waits in the output register.
// Reset: asynchronous; table valid bits clear at once, so no clearing pass is needed.
`include "assert_macros.svh"

module counter_priority_task_scheduler #(
	parameter int TASK_COUNT = cpts_pkg::TASK_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// kernel_mode, slot, present, runnable, priority_req, slice_value, zero pad
	input  logic [31:0] s_tdata,
	// opcode
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// switched, task_index, refreshed, current_slice, zero pad
	output logic [23:0] m_tdata
);
	import cpts_pkg::*;

	localparam int IDX_W = $clog2(TASK_COUNT);

	cpts_item_t       item;
	cpts_result_t     res;
	logic             res_valid;
	logic             res_ready;
	logic [IDX_W-1:0] rd_addr;
	cpts_entry_t      rd_data;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	cpts_entry_t      wr_data;
	logic             m_tvalid_q;
	cpts_result_t     m_res_q;

	// Unpack the input word.
	assign item.opcode       = s_tuser;
	assign item.kernel_mode  = s_tdata[0];
	assign item.slot         = s_tdata[6:1];
	assign item.present      = s_tdata[7];
	assign item.runnable     = s_tdata[8];
	assign item.priority_req = s_tdata[16:9];
	assign item.slice_value  = s_tdata[25:17];

	cpts_table #(
		.TASK_COUNT(TASK_COUNT)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	cpts_core #(
		.TASK_COUNT(TASK_COUNT)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// Output register parts the core from the downstream side.
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_res_q <= res;
		end
	end

	// Pack the result word.
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, m_res_q.current_slice, m_res_q.refreshed,
		m_res_q.task_index, m_res_q.switched};

	`CPTS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted word did not make the block busy")
	`CPTS_ASSERT_NOW(a_refresh_needs_switch, m_tvalid, !m_tdata[7] || m_tdata[0], "refreshed reported without a selection")
	`CPTS_ASSERT_NOW(a_index_in_range, m_tvalid, (9'(m_tdata[6:1]) < 9'(TASK_COUNT)), "current task outside the table")
	`CPTS_ASSERT_NOW(a_single_write, wr_en, !(s_tvalid && s_tready) || (s_tuser == OP_WRITE), "table written while taking a non-write word")

endmodule
